>>> rtl/edra_pkg.sv
// Shared types, curve constants and codes for the excessive descent rate alert.
package edra_pkg;

  // Field widths
  localparam int ALT_W     = 17;
  localparam int TERR_W    = 16;
  localparam int VS_W      = 16;
  localparam int HGT_RAW_W = ALT_W + 1;
  localparam int HEIGHT_W  = 13;
  localparam int DH_W      = 12;
  localparam int SEG_W     = 2;
  localparam int LIM_W     = 16;

  // Reciprocal constants: limit drop = (dh * RECIP) >> RECIP_SHIFT, exact for dh*D < 2^shift
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W     = 26;
  localparam int PROD_W      = DH_W + RECIP_W;
  localparam int DROP_W      = PROD_W - RECIP_SHIFT;

  // Height limits in feet
  localparam logic [HEIGHT_W-1:0] MAX_HEIGHT_FT = 13'd5500;
  localparam logic [HEIGHT_W-1:0] WARN_TOP_FT   = 13'd4400;

  // Caution curve breakpoints
  localparam logic [HEIGHT_W-1:0] CAUT_X [0:3] = '{13'd0, 13'd1500, 13'd3100, 13'd5500};
  localparam logic signed [LIM_W-1:0] CAUT_Y [0:2] =
    '{-16'sd1000, -16'sd2350, -16'sd4850};
  localparam logic [RECIP_W-1:0] CAUT_RECIP [0:2] =
    '{26'd15099495, 26'd26214400, 26'd49982123};

  // Warning curve breakpoints
  localparam logic [HEIGHT_W-1:0] WARN_X [0:3] = '{13'd0, 13'd1150, 13'd2450, 13'd4400};
  localparam logic signed [LIM_W-1:0] WARN_Y [0:2] =
    '{-16'sd1300, -16'sd2350, -16'sd4850};
  localparam logic [RECIP_W-1:0] WARN_RECIP [0:2] =
    '{26'd15318328, 26'd32263877, 26'd61516459};

  // Alert codes
  localparam logic [1:0] ALERT_NONE    = 2'd0;
  localparam logic [1:0] ALERT_CAUTION = 2'd1;
  localparam logic [1:0] ALERT_PULL_UP = 2'd2;

  // Caution stage codes
  localparam logic [1:0] STAGE_NONE = 2'd0;
  localparam logic [1:0] STAGE_LOW  = 2'd1;
  localparam logic [1:0] STAGE_BOTH = 2'd2;

  // Packed stream widths
  localparam int IN_DATA_W  = 56;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 8;

  // One input sample
  typedef struct packed {
    logic signed [ALT_W-1:0]  altitude_ft;
    logic signed [TERR_W-1:0] terrain_ft;
    logic                     terrain_valid;
    logic signed [VS_W-1:0]   vertical_speed_fpm;
    logic                     speed_valid;
    logic                     position_valid;
    logic                     on_ground;
  } sample_t;

  // Height stage result: segment and offset on each curve
  typedef struct packed {
    logic                   ok;
    logic                   has_warn;
    logic signed [VS_W-1:0] vs;
    logic [SEG_W-1:0]       caut_seg;
    logic [DH_W-1:0]        caut_dh;
    logic [SEG_W-1:0]       warn_seg;
    logic [DH_W-1:0]        warn_dh;
  } height_t;

  // Limit stage result: sink limits in ft/min
  typedef struct packed {
    logic                    ok;
    logic                    has_warn;
    logic signed [VS_W-1:0]  vs;
    logic signed [LIM_W-1:0] caut;
    logic signed [LIM_W-1:0] warn;
  } limits_t;

endpackage

>>> rtl/edra_height.sv
// First pipeline stage: height above terrain, gating checks and curve segment lookup.
module edra_height
  import edra_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  sample_t in_sample,
  output logic    out_valid,
  input  logic    out_ready,
  output height_t out_data
);

  logic signed [TERR_W-1:0]    terr;
  logic signed [HGT_RAW_W-1:0] h_raw;
  logic [HEIGHT_W-1:0]         h;
  logic                        h_in_range;
  logic                        load;
  height_t                     data_next;

  assign in_ready = !out_valid || out_ready;
  assign load     = in_valid && in_ready;

  // Compute floored height and pick segments
  always_comb begin
    terr  = in_sample.terrain_valid ? in_sample.terrain_ft : '0;
    h_raw = HGT_RAW_W'(in_sample.altitude_ft) - HGT_RAW_W'(terr);
    if (h_raw[HGT_RAW_W-1]) begin
      h_in_range = 1'b1;
      h          = '0;
    end else begin
      h_in_range = (h_raw <= $signed({{(HGT_RAW_W-HEIGHT_W){1'b0}}, MAX_HEIGHT_FT}));
      h          = h_raw[HEIGHT_W-1:0];
    end

    data_next.ok       = in_sample.position_valid && in_sample.speed_valid &&
                         !in_sample.on_ground && h_in_range;
    data_next.has_warn = (h <= WARN_TOP_FT);
    data_next.vs       = in_sample.vertical_speed_fpm;

    if (h <= CAUT_X[1]) begin
      data_next.caut_seg = 2'd0;
      data_next.caut_dh  = DH_W'(h - CAUT_X[0]);
    end else if (h <= CAUT_X[2]) begin
      data_next.caut_seg = 2'd1;
      data_next.caut_dh  = DH_W'(h - CAUT_X[1]);
    end else begin
      data_next.caut_seg = 2'd2;
      data_next.caut_dh  = DH_W'(h - CAUT_X[2]);
    end

    if (h <= WARN_X[1]) begin
      data_next.warn_seg = 2'd0;
      data_next.warn_dh  = DH_W'(h - WARN_X[0]);
    end else if (h <= WARN_X[2]) begin
      data_next.warn_seg = 2'd1;
      data_next.warn_dh  = DH_W'(h - WARN_X[1]);
    end else begin
      data_next.warn_seg = 2'd2;
      data_next.warn_dh  = DH_W'(h - WARN_X[2]);
    end
  end

  // Hold valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // Capture payload on transfer
  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= data_next;
    end
  end

endmodule

>>> rtl/edra_limits.sv
// Second pipeline stage: interpolate caution and warning sink limits.
module edra_limits
  import edra_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  height_t in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output limits_t out_data
);

  logic [PROD_W-1:0] caut_prod;
  logic [PROD_W-1:0] warn_prod;
  logic [DROP_W-1:0] caut_drop;
  logic [DROP_W-1:0] warn_drop;
  logic [1:0]        caut_idx;
  logic [1:0]        warn_idx;
  logic              load;
  limits_t           data_next;

  assign in_ready = !out_valid || out_ready;
  assign load     = in_valid && in_ready;

  // Multiply offset by the segment reciprocal slope, truncate toward zero
  always_comb begin
    caut_idx  = (in_data.caut_seg == 2'd3) ? 2'd2 : in_data.caut_seg;
    warn_idx  = (in_data.warn_seg == 2'd3) ? 2'd2 : in_data.warn_seg;
    caut_prod = PROD_W'(in_data.caut_dh) * PROD_W'(CAUT_RECIP[caut_idx]);
    warn_prod = PROD_W'(in_data.warn_dh) * PROD_W'(WARN_RECIP[warn_idx]);
    caut_drop = caut_prod[PROD_W-1:RECIP_SHIFT];
    warn_drop = warn_prod[PROD_W-1:RECIP_SHIFT];

    data_next.ok       = in_data.ok;
    data_next.has_warn = in_data.has_warn;
    data_next.vs       = in_data.vs;
    data_next.caut     = CAUT_Y[caut_idx] - $signed({{(LIM_W-DROP_W){1'b0}}, caut_drop});
    data_next.warn     = WARN_Y[warn_idx] - $signed({{(LIM_W-DROP_W){1'b0}}, warn_drop});
  end

  // Hold valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // Capture payload on transfer
  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= data_next;
    end
  end

endmodule

>>> rtl/edra_decide.sv
// Final stage: compare sink rate to limits, update caution stages, register the result.
module edra_decide
  import edra_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  limits_t    in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] alert,
  output logic [1:0] caution_stage
);

  logic                  low_given;
  logic                  high_given;
  logic                  low_given_next;
  logic                  high_given_next;
  logic [1:0]            alert_next;
  logic signed [VS_W:0]  vs2;
  logic signed [VS_W:0]  mid_sum;
  logic signed [LIM_W-1:0] warn_eff;
  logic                  load;

  assign in_ready = !out_valid || out_ready;
  assign load     = in_valid && in_ready;

  // Decide alert and next caution stages
  always_comb begin
    warn_eff        = in_data.has_warn ? in_data.warn : '0;
    vs2             = {in_data.vs, 1'b0};
    mid_sum         = (VS_W+1)'(in_data.caut) + (VS_W+1)'(warn_eff);
    alert_next      = ALERT_NONE;
    low_given_next  = low_given;
    high_given_next = high_given;
    if (!in_data.ok) begin
      low_given_next  = 1'b0;
      high_given_next = 1'b0;
    end else if (in_data.has_warn && (in_data.vs <= in_data.warn)) begin
      low_given_next  = 1'b1;
      high_given_next = 1'b1;
      alert_next      = ALERT_PULL_UP;
    end else if (in_data.vs <= in_data.caut) begin
      if (!low_given) begin
        low_given_next = 1'b1;
        alert_next     = ALERT_CAUTION;
      end else if (!high_given && in_data.has_warn && (vs2 < mid_sum)) begin
        high_given_next = 1'b1;
        alert_next      = ALERT_CAUTION;
      end
    end else begin
      low_given_next  = 1'b0;
      high_given_next = 1'b0;
    end
  end

  // Advance caution stages and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      low_given  <= 1'b0;
      high_given <= 1'b0;
    end else begin
      if (in_ready) begin
        out_valid <= in_valid;
      end
      if (load) begin
        low_given  <= low_given_next;
        high_given <= high_given_next;
      end
    end
  end

  // Capture result on transfer
  always_ff @(posedge clk) begin
    if (load) begin
      alert         <= alert_next;
      caution_stage <= 2'(low_given_next) + 2'(high_given_next);
    end
  end

  // The second stage is never armed without the first
  assert property (@(posedge clk) disable iff (rst) high_given |-> low_given)
    else $error("high caution armed without low caution");

  // A pull-up result always reports both stages armed
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && alert == ALERT_PULL_UP) |-> (caution_stage == STAGE_BOTH))
    else $error("pull-up without both caution stages");

  // Reported stage matches the state left by the item
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (caution_stage == 2'(low_given) + 2'(high_given)))
    else $error("caution stage does not match armed state");

  // Stages hold while a result is stalled
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> ($stable(low_given) && $stable(high_given)))
    else $error("caution stages changed during output stall");

  // A new caution never comes from an invalid sample
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !in_data.ok) |=> (alert == ALERT_NONE && caution_stage == STAGE_NONE))
    else $error("alert raised on rejected sample");

endmodule

>>> rtl/excessive_descent_rate_alert.sv
// Top level of the excessive descent rate alert: stream ports and a three-stage pipeline.
//
//  Channel   Dir  Signals                         Contents
//  s_axis    in   tvalid tready tdata[55:0]       one sample per transfer
//                 tuser[2:0]                      validity flags
//  m_axis    out  tvalid tready tdata[7:0]        alert and caution stage per sample
//
//  One sample per clock cycle is sustained while m_axis_tready is high; each sample is
//  registered in turn in the height stage, the limit multiply stage and the
//  decision/output register, which drives m_axis_tvalid and m_axis_tdata.
//  Synchronous reset clears all stage valid flags and both caution stages.
//  Each stage holds its item while the next stage is full and not draining;
//  s_axis_tready follows from m_axis_tready through the stage chain in the same cycle.
module excessive_descent_rate_alert
  import edra_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [16:0] altitude_ft, [32:17] terrain_ft, [48:33] vertical_speed_fpm,
  // [49] on_ground, [55:50] zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [0] terrain_valid, [1] speed_valid, [2] position_valid
  input  logic [IN_USER_W-1:0]  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [1:0] alert, [3:2] caution_stage, [7:4] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  sample_t    sample;
  height_t    height_data;
  limits_t    limits_data;
  logic       height_valid;
  logic       height_ready;
  logic       limits_valid;
  logic       limits_ready;
  logic [1:0] alert;
  logic [1:0] caution_stage;

  // Unpack the input transfer
  always_comb begin
    sample.altitude_ft        = s_axis_tdata[16:0];
    sample.terrain_ft         = s_axis_tdata[32:17];
    sample.vertical_speed_fpm = s_axis_tdata[48:33];
    sample.on_ground          = s_axis_tdata[49];
    sample.terrain_valid      = s_axis_tuser[0];
    sample.speed_valid        = s_axis_tuser[1];
    sample.position_valid     = s_axis_tuser[2];
  end

  edra_height u_height (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_sample (sample),
    .out_valid (height_valid),
    .out_ready (height_ready),
    .out_data  (height_data)
  );

  edra_limits u_limits (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (height_valid),
    .in_ready  (height_ready),
    .in_data   (height_data),
    .out_valid (limits_valid),
    .out_ready (limits_ready),
    .out_data  (limits_data)
  );

  edra_decide u_decide (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (limits_valid),
    .in_ready      (limits_ready),
    .in_data       (limits_data),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .alert         (alert),
    .caution_stage (caution_stage)
  );

  // Pack the result transfer
  assign m_axis_tdata = {4'b0000, caution_stage, alert};

endmodule
